>>> rtl/core/nssd_pkg.sv
// Package with the shared types, constants and helpers of the spline derivative block.
`default_nettype none
package nssd_pkg;

    // One sample point as it arrives.
    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_point;
    } point_t;

    // One second-derivative result as it leaves.
    typedef struct packed {
        logic signed [39:0] second_derivative;
        logic [5:0]         point_index;
        logic               last_result;
        logic               bad_spacing;
    } result_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // Request to the shared arithmetic unit. Multiply returns a*b/2^22 and divide
    // returns a/b, both truncated toward zero.
    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic signed [65:0] a;
        logic signed [40:0] b;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [65:0] result;
    } alu_resp_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_PRE_RD0,
        ST_PRE_RD1,
        ST_PRE_LATCH,
        ST_PRE_SLOPE,
        ST_STEP_RD,
        ST_STEP_LATCH,
        ST_SIG,
        ST_P,
        ST_C,
        ST_SR,
        ST_Q,
        ST_W,
        ST_U,
        ST_TAIL,
        ST_BACK_RD,
        ST_BACK_MUL,
        ST_EMIT_RD,
        ST_EMIT
    } nssd_state_t;

    localparam int FRAC_BITS = 22;
    localparam logic signed [65:0] ONE_Q  = 66'sd4194304;
    localparam logic signed [65:0] SAT_HI = 66'sd549755813887;
    localparam logic signed [65:0] SAT_LO = -66'sd549755813888;

    // Clamp a wide signed value to the 40-bit result range.
    function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
        logic signed [39:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[39:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[39:0];
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/natural_spline_second_derivatives.sv
// Top level of the natural cubic spline second derivative solver.
`default_nettype none
// Sample points (x, y) in signed Q16.16 stream in one transaction per cycle and are stored
// until a point with last_point set closes the run; points beyond MAX_POINTS are dropped.
// The block then solves the natural spline tridiagonal system with a forward sweep and a
// back substitution and returns one Q24.16 second derivative per stored point, in order,
// with last_result on the final one. All multiplies and divides go through one shared
// bit-serial unit. Each interior point of the sweep costs five divides and two multiplies,
// and each point of the back substitution one multiply; every result is then read out of
// its store before it is offered. Runs shorter than three points, or runs whose x values
// do not strictly increase, skip the solver and return zeros, the latter with bad_spacing
// set. The block takes no new point from the end of a run until its last result has left.
module natural_spline_second_derivatives
    import nssd_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    point_valid,
    output logic         point_ready,
    input  wire point_t  point,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    // Point and sweep stores.
    logic signed [31:0] x_mem [MAX_POINTS];
    logic signed [31:0] y_mem [MAX_POINTS];
    logic signed [39:0] c_mem [MAX_POINTS];
    logic signed [39:0] r_mem [MAX_POINTS];

    nssd_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] idx_reg;
    logic          bad_reg;
    logic          zero_mode_reg;
    logic          issued_reg;
    logic signed [31:0] last_x_reg;

    // Sweep datapath registers: a, b and c hold the points i-1, i and i+1.
    logic signed [31:0] xa_reg, xb_reg, xc_reg;
    logic signed [31:0] yb_reg, yc_reg;
    logic signed [40:0] sig_reg;
    logic signed [40:0] p_reg;
    logic signed [39:0] c_reg;
    logic signed [39:0] u_reg;
    logic signed [39:0] sr_reg;
    logic signed [39:0] sprev_reg;
    logic signed [39:0] q_reg;
    logic signed [39:0] v_reg;
    logic signed [39:0] y2_reg;

    logic signed [31:0] x_rd, y_rd;
    logic signed [39:0] c_rd, r_rd;

    alu_req_t  alu_req;
    alu_resp_t alu_resp;

    logic          accept_in;
    logic          stored;
    logic          op_state;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] w_addr;
    logic          c_we, r_we;
    logic signed [39:0] c_wdata, r_wdata;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] n_last;
    logic [31:0]   idx32;

    logic signed [65:0] dl_w, dr_w, span_w, dy_w, dslope_w, six_w, pv_w;

    nssd_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .resp  (alu_resp)
    );

    assign accept_in = point_valid && point_ready;
    assign stored    = cnt_reg < MAX_CNT;
    assign idx_inc   = idx_reg + CW'(1);
    assign n_last    = n_reg - CW'(1);
    assign idx32     = 32'(idx_reg);

    always_comb
    begin
        dl_w     = 66'(xb_reg) - 66'(xa_reg);
        dr_w     = 66'(xc_reg) - 66'(xb_reg);
        span_w   = 66'(xc_reg) - 66'(xa_reg);
        dy_w     = 66'(yc_reg) - 66'(yb_reg);
        dslope_w = 66'(sr_reg) - 66'(sprev_reg);
        six_w    = (dslope_w <<< 2) + (dslope_w <<< 1);
        pv_w     = alu_resp.result + (ONE_Q <<< 1);
    end

    always_comb
    begin
        unique case (state_reg)
            ST_PRE_SLOPE, ST_SIG, ST_P, ST_C, ST_SR, ST_Q, ST_W, ST_U, ST_BACK_MUL:
                op_state = 1'b1;
            default:
                op_state = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:       if (accept_in && point.last_point) state_next = ST_START;
            ST_START:      state_next = (bad_reg || n_reg < CW'(3)) ? ST_EMIT_RD : ST_PRE_RD0;
            ST_PRE_RD0:    state_next = ST_PRE_RD1;
            ST_PRE_RD1:    state_next = ST_PRE_LATCH;
            ST_PRE_LATCH:  state_next = ST_PRE_SLOPE;
            ST_PRE_SLOPE:  if (alu_resp.done) state_next = ST_STEP_RD;
            ST_STEP_RD:    state_next = ST_STEP_LATCH;
            ST_STEP_LATCH: state_next = ST_SIG;
            ST_SIG:        if (alu_resp.done) state_next = ST_P;
            ST_P:          if (alu_resp.done) state_next = ST_C;
            ST_C:          if (alu_resp.done) state_next = ST_SR;
            ST_SR:         if (alu_resp.done) state_next = ST_Q;
            ST_Q:          if (alu_resp.done) state_next = ST_W;
            ST_W:          if (alu_resp.done) state_next = ST_U;
            ST_U:
                if (alu_resp.done) begin
                    state_next = (idx_inc < n_last) ? ST_STEP_RD : ST_TAIL;
                end
            ST_TAIL:       state_next = ST_BACK_RD;
            ST_BACK_RD:    state_next = ST_BACK_MUL;
            ST_BACK_MUL:
                if (alu_resp.done) begin
                    state_next = (idx_reg == '0) ? ST_EMIT_RD : ST_BACK_RD;
                end
            ST_EMIT_RD:    state_next = ST_EMIT;
            ST_EMIT:
                if (result_ready) begin
                    state_next = (idx_reg == n_last) ? ST_LOAD : ST_EMIT_RD;
                end
            default:       state_next = ST_LOAD;
        endcase
    end

    // Output and control decode.
    always_comb
    begin
        point_ready   = (state_reg == ST_LOAD);
        result_valid  = (state_reg == ST_EMIT);
        alu_req.start = op_state && !issued_reg;
        alu_req.op    = ALU_DIV;
        alu_req.a     = '0;
        alu_req.b     = 41'sd1;
        rd_addr       = idx_reg[IW-1:0];
        w_addr        = idx_reg[IW-1:0];
        c_we          = 1'b0;
        r_we          = 1'b0;
        c_wdata       = '0;
        r_wdata       = '0;
        unique case (state_reg)
            ST_PRE_RD0:
            begin
                rd_addr = '0;
                w_addr  = '0;
                c_we    = 1'b1;
                r_we    = 1'b1;
            end
            ST_PRE_RD1:    rd_addr = IW'(1);
            ST_PRE_SLOPE:
            begin
                alu_req.a = dy_w <<< 16;
                alu_req.b = dr_w[40:0];
            end
            ST_STEP_RD:    rd_addr = idx_inc[IW-1:0];
            ST_SIG:
            begin
                alu_req.a = dl_w <<< FRAC_BITS;
                alu_req.b = span_w[40:0];
            end
            ST_P:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = 66'(sig_reg);
                alu_req.b  = 41'(c_reg);
            end
            ST_C:
            begin
                alu_req.a = (66'(sig_reg) - ONE_Q) <<< FRAC_BITS;
                alu_req.b = p_reg;
                c_we      = alu_resp.done;
                c_wdata   = alu_resp.result[39:0];
            end
            ST_SR:
            begin
                alu_req.a = dy_w <<< 16;
                alu_req.b = dr_w[40:0];
            end
            ST_Q:
            begin
                alu_req.a = six_w <<< 16;
                alu_req.b = span_w[40:0];
            end
            ST_W:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = 66'(sig_reg);
                alu_req.b  = 41'(u_reg);
            end
            ST_U:
            begin
                alu_req.a = 66'(v_reg) <<< FRAC_BITS;
                alu_req.b = p_reg;
                r_we      = alu_resp.done;
                r_wdata   = sat40(alu_resp.result);
            end
            ST_TAIL:
            begin
                w_addr = n_last[IW-1:0];
                r_we   = 1'b1;
            end
            ST_BACK_MUL:
            begin
                alu_req.op = ALU_MUL;
                alu_req.a  = 66'(c_rd);
                alu_req.b  = 41'(y2_reg);
                r_we       = alu_resp.done;
                r_wdata    = sat40(alu_resp.result + 66'(r_rd));
            end
            default:
            begin
            end
        endcase
    end

    assign result.second_derivative = zero_mode_reg ? 40'sd0 : r_rd;
    assign result.point_index       = idx32[5:0];
    assign result.last_result       = (idx_reg == n_last);
    assign result.bad_spacing       = bad_reg;

    // Stores: one write and one registered read each cycle.
    always_ff @(posedge clk)
    begin
        if (accept_in && stored) begin
            x_mem[cnt_reg[IW-1:0]] <= point.x_value;
            y_mem[cnt_reg[IW-1:0]] <= point.y_value;
        end
        if (c_we) begin
            c_mem[w_addr] <= c_wdata;
        end
        if (r_we) begin
            r_mem[w_addr] <= r_wdata;
        end
        x_rd <= x_mem[rd_addr];
        y_rd <= y_mem[rd_addr];
        c_rd <= c_mem[rd_addr];
        r_rd <= r_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            bad_reg       <= 1'b0;
            zero_mode_reg <= 1'b0;
            issued_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (alu_resp.done) begin
                issued_reg <= 1'b0;
            end else if (alu_req.start) begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_LOAD:
                    if (accept_in) begin
                        if (stored && cnt_reg != '0 && point.x_value <= last_x_reg) begin
                            bad_reg <= 1'b1;
                        end
                        if (point.last_point) begin
                            n_reg   <= cnt_reg + (stored ? CW'(1) : CW'(0));
                            cnt_reg <= '0;
                        end else if (stored) begin
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                    end
                ST_START:
                begin
                    zero_mode_reg <= bad_reg || n_reg < CW'(3);
                    idx_reg       <= '0;
                end
                ST_PRE_SLOPE:  if (alu_resp.done) idx_reg <= CW'(1);
                ST_U:          if (alu_resp.done) idx_reg <= idx_inc;
                ST_TAIL:       idx_reg <= n_reg - CW'(2);
                ST_BACK_MUL:
                    if (alu_resp.done && idx_reg != '0) begin
                        idx_reg <= idx_reg - CW'(1);
                    end
                ST_EMIT:
                    if (result_ready) begin
                        if (idx_reg == n_last) begin
                            idx_reg <= '0;
                            bad_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                default:
                begin
                end
            endcase
        end
    end

    // Sweep datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept_in && stored) begin
            last_x_reg <= point.x_value;
        end
        case (state_reg)
            ST_PRE_RD1:
            begin
                xb_reg <= x_rd;
                yb_reg <= y_rd;
            end
            ST_PRE_LATCH:
            begin
                xc_reg <= x_rd;
                yc_reg <= y_rd;
                c_reg  <= '0;
                u_reg  <= '0;
            end
            ST_PRE_SLOPE:  if (alu_resp.done) sprev_reg <= sat40(alu_resp.result);
            ST_STEP_RD:
            begin
                xa_reg <= xb_reg;
                xb_reg <= xc_reg;
                yb_reg <= yc_reg;
            end
            ST_STEP_LATCH:
            begin
                xc_reg <= x_rd;
                yc_reg <= y_rd;
            end
            ST_SIG:        if (alu_resp.done) sig_reg <= alu_resp.result[40:0];
            ST_P:
                if (alu_resp.done) begin
                    p_reg <= (pv_w < 66'sd1) ? 41'sd1 : pv_w[40:0];
                end
            ST_C:          if (alu_resp.done) c_reg <= alu_resp.result[39:0];
            ST_SR:         if (alu_resp.done) sr_reg <= sat40(alu_resp.result);
            ST_Q:          if (alu_resp.done) q_reg <= sat40(alu_resp.result);
            ST_W:          if (alu_resp.done) v_reg <= sat40(66'(q_reg) - alu_resp.result);
            ST_U:
                if (alu_resp.done) begin
                    u_reg     <= sat40(alu_resp.result);
                    sprev_reg <= sr_reg;
                end
            ST_TAIL:       y2_reg <= '0;
            ST_BACK_MUL:   if (alu_resp.done) y2_reg <= r_wdata;
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A flagged run never reports a nonzero derivative.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_spacing |-> result.second_derivative == 40'sd0)
        else $error("bad spacing result carries a nonzero value");

    // Taking the final result of a run reopens the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_result |=> point_ready)
        else $error("input not reopened after last result");

    // The arithmetic unit only answers a request the sequencer issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_resp.done |-> issued_reg && op_state)
        else $error("arithmetic unit answered without a request");
`endif

endmodule
`default_nettype wire

>>> rtl/core/nssd_alu.sv
// Shared sign-magnitude multiply and restoring divide unit, one bit per cycle.
`default_nettype none
module nssd_alu
    import nssd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire alu_req_t  req,
    output alu_resp_t      resp
);
    localparam logic [6:0] DIV_STEPS = 7'd65;
    localparam logic [6:0] MUL_STEPS = 7'd40;

    logic               busy_reg;
    logic               done_reg;
    logic [6:0]         cnt_reg;
    alu_op_t            op_reg;
    logic               neg_reg;
    logic [64:0]        qa_reg;
    logic [41:0]        rem_reg;
    logic [40:0]        d_reg;
    logic [80:0]        acc_reg;
    logic [39:0]        mb_reg;
    logic signed [65:0] result_reg;

    logic signed [65:0] abs_a;
    logic signed [40:0] abs_b;
    logic [41:0]        trial;
    logic               fits;
    logic [41:0]        trial_diff;
    logic [64:0]        mag_fin;
    logic [6:0]         steps;
    logic               finish;

    always_comb
    begin
        abs_a      = req.a[65] ? -req.a : req.a;
        abs_b      = req.b[40] ? -req.b : req.b;
        trial      = {rem_reg[40:0], qa_reg[64]};
        fits       = trial >= {1'b0, d_reg};
        trial_diff = trial - {1'b0, d_reg};
        steps      = (op_reg == ALU_DIV) ? DIV_STEPS : MUL_STEPS;
        finish     = busy_reg && (cnt_reg == steps);
        if (op_reg == ALU_DIV) begin
            mag_fin = qa_reg;
        end else begin
            mag_fin = {6'd0, acc_reg[80:FRAC_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (finish) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start) begin
            op_reg  <= req.op;
            neg_reg <= req.a[65] ^ req.b[40];
            qa_reg  <= abs_a[64:0];
            d_reg   <= abs_b;
            mb_reg  <= abs_b[39:0];
            rem_reg <= '0;
            acc_reg <= '0;
        end else if (finish) begin
            result_reg <= neg_reg ? -$signed({1'b0, mag_fin}) : $signed({1'b0, mag_fin});
        end else if (busy_reg) begin
            if (op_reg == ALU_DIV) begin
                rem_reg <= fits ? trial_diff : trial;
                qa_reg  <= {qa_reg[63:0], fits};
            end else begin
                acc_reg <= {acc_reg[79:0], 1'b0} + (mb_reg[39] ? {40'd0, qa_reg[40:0]} : 81'd0);
                mb_reg  <= {mb_reg[38:0], 1'b0};
            end
        end
    end

    assign resp.done   = done_reg;
    assign resp.result = result_reg;

endmodule
`default_nettype wire

>>> tb/spline_checker.sv
// Checker that predicts spline second derivatives from observed points and compares results.
`default_nettype none
module spline_checker
    import nssd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    point_valid,
    input  wire logic    point_ready,
    input  wire point_t  point,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result,
    output int           mismatches,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam longint ONE = 64'sd4194304;
    localparam longint HI40 = 64'sd549755813887;
    localparam longint LO40 = -64'sd549755813888;

    longint run_x [DEPTH];
    longint run_y [DEPTH];
    int     run_len;
    result_t expected_results [$];

    function automatic longint clamp40(input longint v);
        if (v > HI40) return HI40;
        if (v < LO40) return LO40;
        return v;
    endfunction

    // Solve the natural spline for the collected run and queue one result per point.
    task automatic solve_run();
        longint coef [DEPTH];
        longint y2 [DEPTH];
        longint dl, dr, span, sig, p, sr, sl, q, v;
        bit bad;
        result_t r;
        int n;
        n = run_len;
        bad = 0;
        for (int k = 1; k < n; k++)
            if (run_x[k] <= run_x[k-1]) bad = 1;
        for (int k = 0; k < n; k++) y2[k] = 0;
        if (!bad && n >= 3) begin
            coef[0] = 0;
            for (int i = 1; i < n - 1; i++) begin
                dl = run_x[i] - run_x[i-1];
                dr = run_x[i+1] - run_x[i];
                span = run_x[i+1] - run_x[i-1];
                sig = dl * ONE / span;
                p = sig * coef[i-1] / ONE + 2 * ONE;
                if (p < 1) p = 1;
                coef[i] = (sig - ONE) * ONE / p;
                sr = clamp40((run_y[i+1] - run_y[i]) * 65536 / dr);
                sl = clamp40((run_y[i] - run_y[i-1]) * 65536 / dl);
                q = clamp40(6 * (sr - sl) * 65536 / span);
                v = clamp40(q - sig * y2[i-1] / ONE);
                y2[i] = clamp40(v * ONE / p);
            end
            y2[n-1] = 0;
            for (int i = n - 2; i >= 0; i--)
                y2[i] = clamp40(coef[i] * y2[i+1] / ONE + y2[i]);
        end
        for (int k = 0; k < n; k++) begin
            r.second_derivative = y2[k][39:0];
            r.point_index = k[5:0];
            r.last_result = (k == n - 1);
            r.bad_spacing = bad;
            expected_results.push_back(r);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            run_len = 0;
            mismatches = 0;
            results_seen <= 0;
            expected_results.delete();
        end else begin
            if (result_valid && result_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report("unexpected result", result.point_index, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (result.second_derivative !== want.second_derivative)
                        report("second_derivative", result.second_derivative,
                               want.second_derivative);
                    if (result.point_index !== want.point_index)
                        report("point_index", result.point_index, want.point_index);
                    if (result.last_result !== want.last_result)
                        report("last_result", result.last_result, want.last_result);
                    if (result.bad_spacing !== want.bad_spacing)
                        report("bad_spacing", result.bad_spacing, want.bad_spacing);
                end
            end
            if (point_valid && point_ready) begin
                // Blocking updates keep the run visible to the solver in this same edge.
                if (run_len < DEPTH) begin
                    run_x[run_len] = longint'(point.x_value);
                    run_y[run_len] = longint'(point.y_value);
                    run_len = run_len + 1;
                end
                if (point.last_point) begin
                    solve_run();
                    run_len = 0;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench top that drives sample-point runs into the spline solver and reports the verdict.
`default_nettype none
module tb_top;
    import nssd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog limit covers a full 64-point solve plus stalls, taken several times over.
    localparam int STALL_LIMIT = 200000;

    logic    clk = 0;
    logic    rst_n = 0;
    logic    point_valid = 0;
    logic    point_ready;
    point_t  point = '0;
    logic    result_valid;
    logic    result_ready = 0;
    result_t result;
    int      mismatches, pending, results_seen;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      points_sent = 0;
    int      runs_sent = 0;
    int      quiet_cycles = 0;

    always #10 clk = ~clk;

    natural_spline_second_derivatives dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    spline_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
    );

    // The receiver stalls at random by the current percentage, decided each cycle.
    always @(posedge clk) begin
        result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // The watchdog ends the run when nothing has been accepted for too long.
    always @(posedge clk) begin
        if ((point_valid && point_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one point and hold it until the transaction completes. Idle cycles
    // come before raising valid, so valid never drops between back-to-back points.
    task automatic send_point(input logic [31:0] xv, input logic [31:0] yv, input bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            point_valid <= 0;
            @(posedge clk);
        end
        point_valid <= 1;
        point.x_value <= xv;
        point.y_value <= yv;
        point.last_point <= last;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
        points_sent++;
        if (last) runs_sent++;
    endtask

    task automatic park_sender();
        point_valid <= 0;
    endtask

    // Send a run of n points with strictly rising x. The step width and the y
    // swing are chosen at random, sometimes huge to push the saturation paths.
    task automatic send_rising_run(input int n, input bit wild);
        logic [31:0] xv, yv;
        int step_max;
        step_max = wild ? 32'h0100_0000 : 32'h0004_0000;
        xv = wild ? 32'h8000_0000 + $urandom_range(1000) : $urandom_range(32'h0010_0000)
             - 32'h0008_0000;
        for (int k = 0; k < n; k++) begin
            yv = wild ? $urandom : $urandom_range(32'h0020_0000) - 32'h0010_0000;
            send_point(xv, yv, k == n - 1);
            xv = xv + 1 + $urandom_range(step_max);
        end
    endtask

    // Send a run of n points with fully random x; this almost always breaks
    // the spacing rule.
    task automatic send_noise_run(input int n);
        for (int k = 0; k < n; k++)
            send_point($urandom, $urandom, k == n - 1);
    endtask

    task automatic wait_drained();
        park_sender();
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial begin
        int kind, n;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: single point, two points, three points, equal x, falling x,
        // extreme coordinates with steep slopes that saturate, and unit steps across zero.
        send_point(32'h0000_0000, 32'h7FFF_FFFF, 1);
        send_point(32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_point(32'h0000_0000, 32'h0000_0000, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h0002_0000, 32'h0000_0000, 1);
        send_point(32'h0001_0000, 32'h0000_0000, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h0002_0000, 32'h0000_0000, 1);
        send_point(32'h0003_0000, 32'h0000_0000, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h0005_0000, 32'h0000_0000, 1);
        send_point(32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h8000_0001, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0002, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 0);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 0);
        send_point(32'h0000_0001, 32'h0000_0000, 1);
        wait_drained();

        // One run that overfills the store; the closing point is dropped but ends it.
        send_rising_run(66, 0);
        wait_drained();

        // Random runs across four idling phases, mostly well formed and short.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            for (int r = 0; r < 10; r++) begin
                kind = $urandom_range(9);
                n = $urandom_range(1, 8);
                if (kind < 6) send_rising_run(n, 0);
                else if (kind < 8) send_rising_run(n, 1);
                else send_noise_run(n);
                if ($urandom_range(3) == 0) wait_drained();
            end
            // The sender holds off here until every queued result has arrived.
            wait_drained();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_drained();
        repeat (50) @(posedge clk);

        $display("covered %0d points in %0d runs, %0d results checked", points_sent,
                 runs_sent, results_seen);
        $display("runs included short, badly spaced, saturating and overfull cases");
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
